>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the frame interval statistics block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked only while reset is released.
`define FIS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked at every clock edge, in reset too.
`define FIS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FIS_ASSERT(lbl, clk, rst_n, prop, msg)
`define FIS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> design/fis_pkg.sv
// ---------------------------------------------------------------------------
// fis_pkg
// Types and constants shared by the frame interval statistics modules.
// ---------------------------------------------------------------------------
`default_nettype none

package fis_pkg;

	localparam int TIME_W  = 24;
	localparam int RATE_W  = 20;
	localparam int SEC_W   = 25;
	localparam int CNT_W   = 32;
	localparam int SUM_W   = 56;
	localparam int ELAP_W  = 33;
	localparam int DUR_W   = 32;

	localparam logic [DUR_W-1:0] WINDOW_DURATION_RESET = 32'd1000000;

	localparam logic CMD_FRAME = 1'b0;
	localparam logic CMD_BEGIN = 1'b1;

	typedef struct packed {
		logic              cmd;
		logic [TIME_W-1:0] frame_time_us;
	} in_item_t;

	typedef struct packed {
		logic [RATE_W-1:0] frames_per_second;
		logic              window_done;
		logic              start_ignored;
		logic [CNT_W-1:0]  window_frames;
		logic [TIME_W-1:0] window_min_us;
		logic [TIME_W-1:0] window_max_us;
		logic [TIME_W-1:0] window_avg_us;
	} out_item_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_PUSH
	} fis_state_t;

	typedef struct packed {
		logic update;
		logic push;
	} fis_cmd_t;

	typedef struct packed {
		logic closing;
		logic div_done;
	} fis_stat_t;

endpackage

`default_nettype wire

>>> design/frame_interval_statistics.sv
// ---------------------------------------------------------------------------
// frame_interval_statistics
// Per-second frame rate and profiling window min, max and average monitor.
// ---------------------------------------------------------------------------
// Every input transfer yields exactly one result transfer. A frame item or a
// begin command that does not close a window goes from the idle state to
// the push state; a frame that closes a window first passes the divide
// state, where the restoring divider forms the average one quotient bit
// per cycle over the 56-bit window sum. A new item is taken as soon as the
// previous result has moved to the output register, even while it waits.
// The window duration register can be written at any time the block is idle.
`default_nettype none

module frame_interval_statistics #(
	parameter int ONE_SECOND_US = 1000000
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire fis_pkg::in_item_t    in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output fis_pkg::out_item_t        out_data,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [31:0]          cfg_data
);
	import fis_pkg::*;

	fis_cmd_t  cmd;
	fis_stat_t status;

	fis_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	fis_dp #(
		.ONE_SECOND_US (ONE_SECOND_US)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

>>> design/fis_div.sv
// ---------------------------------------------------------------------------
// fis_div
// Restoring divider, one quotient bit per cycle, saturated to the avg width.
// ---------------------------------------------------------------------------
`default_nettype none

module fis_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [fis_pkg::SUM_W-1:0]   dividend,
	input  wire logic [fis_pkg::CNT_W-1:0]   divisor,
	output logic                             done,
	output logic [fis_pkg::TIME_W-1:0]       quotient
);
	import fis_pkg::*;

	localparam int STEP_W = $clog2(SUM_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

	logic [SUM_W-1:0]  quot_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dvs_q;
	logic [STEP_W-1:0] step_q;
	logic              run_q;
	logic              done_q;
	logic [CNT_W:0]    trial;
	logic [CNT_W:0]    diff;
	logic              ge;

	assign trial = {rem_q, quot_q[SUM_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= LAST_STEP;
			end else if (run_q) begin
				if (step_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (run_q) begin
			rem_q  <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			quot_q <= {quot_q[SUM_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = (|quot_q[SUM_W-1:TIME_W]) ? '1 : quot_q[TIME_W-1:0];

endmodule

`default_nettype wire

>>> design/fis_dp.sv
// ---------------------------------------------------------------------------
// fis_dp
// Accumulators, configuration register, divider and result registers.
// ---------------------------------------------------------------------------
`default_nettype none

module fis_dp #(
	parameter int ONE_SECOND_US = 1000000
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire fis_pkg::in_item_t    in_data,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [31:0]          cfg_data,
	input  wire fis_pkg::fis_cmd_t    cmd,
	output fis_pkg::fis_stat_t        status,
	output fis_pkg::out_item_t        out_data
);
	import fis_pkg::*;

	localparam logic [SEC_W:0] ONE_SEC = (SEC_W + 1)'(ONE_SECOND_US);

	logic [DUR_W-1:0]  dur_q;
	logic [RATE_W-1:0] sf_q;
	logic [SEC_W-1:0]  se_q;
	logic [RATE_W-1:0] rate_q;
	logic              active_q;
	logic [ELAP_W-1:0] we_q;
	logic [CNT_W-1:0]  wc_q;
	logic [SUM_W-1:0]  ws_q;
	logic [TIME_W-1:0] lo_q;
	logic [TIME_W-1:0] hi_q;
	out_item_t         pend_q;
	out_item_t         out_q;

	logic [TIME_W-1:0] t;
	logic              is_frame;
	logic [RATE_W-1:0] sf_inc;
	logic [SEC_W:0]    se_sum;
	logic              se_over;
	logic [SEC_W:0]    se_adj;
	logic [SEC_W-1:0]  se_next;
	logic [RATE_W-1:0] rate_next;
	logic [CNT_W-1:0]  wc_next;
	logic [SUM_W:0]    ws_sum;
	logic [SUM_W-1:0]  ws_next;
	logic [ELAP_W:0]   we_sum;
	logic [ELAP_W-1:0] we_next;
	logic [TIME_W-1:0] lo_next;
	logic [TIME_W-1:0] hi_next;
	logic              closing;
	logic              div_done;
	logic [TIME_W-1:0] div_q;

	assign t        = in_data.frame_time_us;
	assign is_frame = in_data.cmd == CMD_FRAME;

	assign sf_inc    = (sf_q == '1) ? sf_q : sf_q + 1'b1;
	assign se_sum    = {1'b0, se_q} + {2'b0, t};
	assign se_over   = se_sum > ONE_SEC;
	assign se_adj    = se_over ? se_sum - ONE_SEC : se_sum;
	assign se_next   = se_adj[SEC_W] ? '1 : se_adj[SEC_W-1:0];
	assign rate_next = se_over ? sf_inc : rate_q;

	assign wc_next = (wc_q == '1) ? wc_q : wc_q + 1'b1;
	assign ws_sum  = {1'b0, ws_q} + {(SUM_W - TIME_W + 1)'(0), t};
	assign ws_next = ws_sum[SUM_W] ? '1 : ws_sum[SUM_W-1:0];
	assign we_sum  = {1'b0, we_q} + {(ELAP_W - TIME_W + 1)'(0), t};
	assign we_next = we_sum[ELAP_W-1:0];
	assign lo_next = (t < lo_q) ? t : lo_q;
	assign hi_next = (t > hi_q) ? t : hi_q;
	assign closing = is_frame && active_q && (we_next > {1'b0, dur_q});

	assign status.closing  = closing;
	assign status.div_done = div_done;
	assign cfg_ready       = 1'b1;

	fis_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.update && closing),
		.dividend (ws_next),
		.divisor  (wc_next),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_q    <= WINDOW_DURATION_RESET;
			sf_q     <= '0;
			se_q     <= '0;
			rate_q   <= '0;
			active_q <= 1'b0;
			we_q     <= '0;
			wc_q     <= '0;
			ws_q     <= '0;
			lo_q     <= '1;
			hi_q     <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				dur_q <= cfg_data;
			end
			if (cmd.update) begin
				if (is_frame) begin
					sf_q   <= se_over ? '0 : sf_inc;
					se_q   <= se_next;
					rate_q <= rate_next;
					if (active_q) begin
						wc_q <= wc_next;
						ws_q <= ws_next;
						we_q <= we_next;
						lo_q <= lo_next;
						hi_q <= hi_next;
						if (closing) begin
							active_q <= 1'b0;
						end
					end
				end else if (!active_q) begin
					active_q <= 1'b1;
					we_q     <= '0;
					wc_q     <= '0;
					ws_q     <= '0;
					lo_q     <= '1;
					hi_q     <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			pend_q.frames_per_second <= is_frame ? rate_next : rate_q;
			pend_q.window_done       <= closing;
			pend_q.start_ignored     <= !is_frame && active_q;
			pend_q.window_frames     <= closing ? wc_next : '0;
			pend_q.window_min_us     <= closing ? lo_next : '0;
			pend_q.window_max_us     <= closing ? hi_next : '0;
			pend_q.window_avg_us     <= '0;
		end else if (div_done) begin
			pend_q.window_avg_us <= div_q;
		end
		if (cmd.push) begin
			out_q <= pend_q;
		end
	end

	assign out_data = out_q;

endmodule

`default_nettype wire

>>> design/fis_ctrl.sv
// ---------------------------------------------------------------------------
// fis_ctrl
// Sequencer for input acceptance, average division and result handoff.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fis_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	input  wire fis_pkg::fis_stat_t   status,
	output fis_pkg::fis_cmd_t         cmd
);
	import fis_pkg::*;

	fis_state_t state_q;
	fis_state_t state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = status.closing ? S_DIV : S_PUSH;
				end
			end
			S_DIV: begin
				if (status.div_done) begin
					state_d = S_PUSH;
				end
			end
			S_PUSH: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd.update = 1'b0;
		cmd.push   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.update = in_valid;
			end
			S_DIV: begin
			end
			S_PUSH: begin
				cmd.push = slot_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`FIS_ASSERT(a_div_done_in_div, clk, arst_n, status.div_done |-> state_q == S_DIV, "divider finished outside the divide state")
	`FIS_ASSERT(a_push_no_overwrite, clk, arst_n, cmd.push |-> slot_free, "result pushed over an untaken result")
	`FIS_ASSERT(a_close_starts_div, clk, arst_n, (cmd.update && status.closing) |=> state_q == S_DIV, "closing frame did not start the division")
	`FIS_ASSERT(a_update_idle_only, clk, arst_n, cmd.update |-> state_q == S_IDLE && in_valid, "state updated without an input transfer")

endmodule

`default_nettype wire
